// ----- src/bsm_pkg.sv -----
// bsm_pkg: transaction types and instruction, kind and error codes
// for the stack machine core; no dependencies
package bsm_pkg;

    // instruction codes
    localparam logic [2:0] MODE_PUSH      = 3'd0;
    localparam logic [2:0] MODE_PRINT_ALL = 3'd1;
    localparam logic [2:0] MODE_PRINT_TOP = 3'd2;
    localparam logic [2:0] MODE_POP       = 3'd3;
    localparam logic [2:0] MODE_SWAP      = 3'd4;
    localparam logic [2:0] MODE_ADD       = 3'd5;
    localparam logic [2:0] MODE_NOP       = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_NOP   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_PRINT_EMPTY = 3'd1;
    localparam logic [2:0] ERR_POP_EMPTY  = 3'd2;
    localparam logic [2:0] ERR_SWAP_SHORT = 3'd3;
    localparam logic [2:0] ERR_ADD_SHORT  = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd5;
    localparam logic [2:0] ERR_HALTED     = 3'd6;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] out_value;
        logic [2:0]         error_code;
        logic               last;
    } rsp_t;

endpackage

// ----- src/bytecode_stack_machine_core.sv -----
// bytecode_stack_machine_core: one instruction per command transaction,
// operands kept in a single-port-read synchronous stack memory
// depends on bsm_pkg
// push, pop, nop, errors and the unused code are done in S_IDLE; print top reads, then
//   answers in S_TOP; add and swap read the top, the second in S_SECOND, and write in
//   S_ADD_W or S_SWAP_W and S_SWAP_W2; print all answers in S_DUMP, one result a cycle
//   when not stalled; reset clears depth, halt flag, sequencer and result valid flag;
//   stack words are left unknown, only entries below the depth are ever read
module bytecode_stack_machine_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  bsm_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bsm_pkg::rsp_t rsp
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TOP    = 3'd1;  // print top, read data arriving
    localparam logic [2:0] S_DUMP   = 3'd2;  // print all, one element a cycle when not stalled
    localparam logic [2:0] S_SECOND = 3'd3;  // top arrived, fetch the one below
    localparam logic [2:0] S_SWAP_W = 3'd4;  // write second into top slot
    localparam logic [2:0] S_SWAP_W2 = 3'd5; // write old top into second slot
    localparam logic [2:0] S_ADD_W  = 3'd6;  // write the sum, drop one

    // stack memory, one write and one registered read per cycle
    logic [31:0]   stack_mem [STACK_DEPTH];
    logic [31:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [2:0]    state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          halted_reg, halted_next;
    logic          is_add_reg, is_add_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [31:0]   top_reg, top_next;
    logic          rsp_valid_reg, rsp_valid_next;
    bsm_pkg::rsp_t rsp_reg, rsp_next;

    logic          out_free;
    logic          accept;
    logic          load_rsp;
    bsm_pkg::rsp_t load_data;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;

    // the result slot can take a new transaction when empty or being drained
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = !((state_reg == S_IDLE) && out_free);
    assign accept    = cmd_valid && !cmd_stall;
    assign depth_m1  = depth_reg - DW'(1);
    assign depth_m2  = depth_reg - DW'(2);

    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        halted_next = halted_reg;
        is_add_next = is_add_reg;
        ptr_next    = ptr_reg;
        top_next    = top_reg;
        mem_we      = 1'b0;
        mem_waddr   = depth_reg[AW-1:0];
        mem_wdata   = cmd.push_value;
        mem_re      = 1'b0;
        mem_raddr   = depth_m1[AW-1:0];
        load_rsp    = 1'b0;
        load_data   = '{kind: bsm_pkg::KIND_ERROR, out_value: 32'sd0,
                        error_code: bsm_pkg::ERR_NONE, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (halted_reg)
                    begin
                        // halted: every command answers with the halted error
                        load_rsp             = 1'b1;
                        load_data.error_code = bsm_pkg::ERR_HALTED;
                    end
                    else
                    begin
                        unique case (cmd.mode) inside
                            bsm_pkg::MODE_PUSH:
                            begin
                                if (depth_reg == DW'(STACK_DEPTH))
                                begin
                                    load_rsp             = 1'b1;
                                    load_data.error_code = bsm_pkg::ERR_OVERFLOW;
                                    halted_next          = 1'b1;
                                end
                                else
                                begin
                                    mem_we     = 1'b1;
                                    depth_next = depth_reg + DW'(1);
                                end
                            end
                            bsm_pkg::MODE_PRINT_ALL:
                            begin
                                // empty stack prints nothing
                                if (depth_reg != '0)
                                begin
                                    mem_re     = 1'b1;
                                    ptr_next   = depth_m1[AW-1:0];
                                    state_next = S_DUMP;
                                end
                            end
                            bsm_pkg::MODE_PRINT_TOP:
                            begin
                                if (depth_reg == '0)
                                begin
                                    load_rsp             = 1'b1;
                                    load_data.error_code = bsm_pkg::ERR_PRINT_EMPTY;
                                    halted_next          = 1'b1;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    state_next = S_TOP;
                                end
                            end
                            bsm_pkg::MODE_POP:
                            begin
                                if (depth_reg == '0)
                                begin
                                    load_rsp             = 1'b1;
                                    load_data.error_code = bsm_pkg::ERR_POP_EMPTY;
                                    halted_next          = 1'b1;
                                end
                                else
                                begin
                                    depth_next = depth_m1;
                                end
                            end
                            bsm_pkg::MODE_SWAP, bsm_pkg::MODE_ADD:
                            begin
                                if (depth_reg < DW'(2))
                                begin
                                    load_rsp             = 1'b1;
                                    load_data.error_code =
                                        (cmd.mode == bsm_pkg::MODE_ADD) ?
                                        bsm_pkg::ERR_ADD_SHORT : bsm_pkg::ERR_SWAP_SHORT;
                                    halted_next          = 1'b1;
                                end
                                else
                                begin
                                    mem_re      = 1'b1;
                                    is_add_next = (cmd.mode == bsm_pkg::MODE_ADD);
                                    state_next  = S_SECOND;
                                end
                            end
                            bsm_pkg::MODE_NOP:
                            begin
                                load_rsp       = 1'b1;
                                load_data.kind = bsm_pkg::KIND_NOP;
                            end
                            default:
                            begin
                                // unused code: no result, no change
                            end
                        endcase
                    end
                end
            end
            S_TOP:
            begin
                if (out_free)
                begin
                    load_rsp            = 1'b1;
                    load_data.kind      = bsm_pkg::KIND_VALUE;
                    load_data.out_value = rd_data_reg;
                    state_next          = S_IDLE;
                end
            end
            S_DUMP:
            begin
                // read data holds while the result slot is busy
                if (out_free)
                begin
                    load_rsp            = 1'b1;
                    load_data.kind      = bsm_pkg::KIND_VALUE;
                    load_data.out_value = rd_data_reg;
                    load_data.last      = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg - AW'(1);
                        ptr_next  = ptr_reg - AW'(1);
                    end
                end
            end
            S_SECOND:
            begin
                top_next   = rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = depth_m2[AW-1:0];
                state_next = is_add_reg ? S_ADD_W : S_SWAP_W;
            end
            S_SWAP_W:
            begin
                mem_we     = 1'b1;
                mem_waddr  = depth_m1[AW-1:0];
                mem_wdata  = rd_data_reg;
                state_next = S_SWAP_W2;
            end
            S_SWAP_W2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = depth_m2[AW-1:0];
                mem_wdata  = top_reg;
                state_next = S_IDLE;
            end
            S_ADD_W:
            begin
                // sum wraps modulo 2^32
                mem_we     = 1'b1;
                mem_waddr  = depth_m2[AW-1:0];
                mem_wdata  = rd_data_reg + top_reg;
                depth_next = depth_m1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result register: load, or drain when taken
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load_rsp)
        begin
            rsp_next       = load_data;
            rsp_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            halted_reg    <= halted_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        is_add_reg <= is_add_next;
        ptr_reg    <= ptr_next;
        top_reg    <= top_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- test/bytecode_stack_machine_core_test.sv -----
`timescale 1ns / 100ps
// bytecode_stack_machine_core_test: self-checking bench for the stack machine core,
// with a behavioral copy of the stack, random valid/stall pacing and result checks
// depends on bsm_pkg and bytecode_stack_machine_core
module bytecode_stack_machine_core_test;

    localparam int STACK_DEPTH = 64;
    localparam int ITEM_COUNT = 500;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1000000;
    // code 7 has no instruction behind it
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    bsm_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    bsm_pkg::rsp_t rsp;

    // instruction stream waiting to be driven, results still owed by the core
    bsm_pkg::cmd_t program_queue[$];
    bsm_pkg::rsp_t results_due[$];

    // behavioral copy of the machine state
    logic signed [31:0] shadow_stack[STACK_DEPTH];
    int stack_level = 0;
    bit machine_halted = 1'b0;

    // stack depth as the generator sees it, so the stream stays legal
    int gen_depth = 0;
    int queued_items = 0;
    int items_total = 0;
    int items_sent = 0;

    int send_gap = 0;
    int send_quiet = 0;
    int recv_hold = 0;
    int recv_quiet = 0;
    int mismatches = 0;
    int cycle_count = 0;

    bytecode_stack_machine_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #1 clk = ~clk;

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // idle or stall length for one transaction, with occasional quiet stretches
    function automatic int pick_wait(inout int quiet_run);
        if (quiet_run > 0)
        begin
            quiet_run--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            quiet_run = $urandom_range(10, 40);
        return $urandom_range(0, 5);
    endfunction

    // operand values lean toward the corners of the 32-bit range
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            4: return 32'($urandom_range(0, 15));
            default: return 32'($urandom);
        endcase
    endfunction

    // append one instruction and keep the generator's depth in step
    task automatic queue_item(input logic [2:0] op, input logic signed [31:0] value);
        bsm_pkg::cmd_t c;
        c.mode = op;
        c.push_value = value;
        program_queue.push_back(c);
        if (op != MODE_UNUSED)
            queued_items++;
        if (op == bsm_pkg::MODE_PUSH && gen_depth < STACK_DEPTH)
            gen_depth++;
        else if (op == bsm_pkg::MODE_POP && gen_depth > 0)
            gen_depth--;
        else if (op == bsm_pkg::MODE_ADD && gen_depth >= 2)
            gen_depth--;
    endtask

    // any error: one error result, then the machine stays halted
    task automatic halt_with(input logic [2:0] code);
        bsm_pkg::rsp_t r;
        r = '0;
        r.kind = bsm_pkg::KIND_ERROR;
        r.error_code = code;
        r.last = 1'b1;
        results_due.push_back(r);
        machine_halted = 1'b1;
    endtask

    // run one accepted instruction on the shadow stack and queue its results
    task automatic execute_instruction(input bsm_pkg::cmd_t c);
        bsm_pkg::rsp_t r;
        logic signed [31:0] held;
        int k;
        r = '0;
        r.last = 1'b1;
        if (machine_halted)
        begin
            r.kind = bsm_pkg::KIND_ERROR;
            r.error_code = bsm_pkg::ERR_HALTED;
            results_due.push_back(r);
        end
        else
        begin
            case (c.mode)
                bsm_pkg::MODE_PUSH:
                    if (stack_level >= STACK_DEPTH)
                        halt_with(bsm_pkg::ERR_OVERFLOW);
                    else
                    begin
                        shadow_stack[stack_level] = c.push_value;
                        stack_level++;
                    end
                bsm_pkg::MODE_PRINT_ALL:
                    // top first, last flag only on the bottom element
                    for (k = stack_level - 1; k >= 0; k--)
                    begin
                        r.kind = bsm_pkg::KIND_VALUE;
                        r.out_value = shadow_stack[k];
                        r.last = (k == 0);
                        results_due.push_back(r);
                    end
                bsm_pkg::MODE_PRINT_TOP:
                    if (stack_level == 0)
                        halt_with(bsm_pkg::ERR_PRINT_EMPTY);
                    else
                    begin
                        r.kind = bsm_pkg::KIND_VALUE;
                        r.out_value = shadow_stack[stack_level - 1];
                        results_due.push_back(r);
                    end
                bsm_pkg::MODE_POP:
                    if (stack_level == 0)
                        halt_with(bsm_pkg::ERR_POP_EMPTY);
                    else
                        stack_level--;
                bsm_pkg::MODE_SWAP:
                    if (stack_level < 2)
                        halt_with(bsm_pkg::ERR_SWAP_SHORT);
                    else
                    begin
                        held = shadow_stack[stack_level - 1];
                        shadow_stack[stack_level - 1] = shadow_stack[stack_level - 2];
                        shadow_stack[stack_level - 2] = held;
                    end
                bsm_pkg::MODE_ADD:
                    if (stack_level < 2)
                        halt_with(bsm_pkg::ERR_ADD_SHORT);
                    else
                    begin
                        // 32-bit sum, wraps on overflow
                        shadow_stack[stack_level - 2] =
                            shadow_stack[stack_level - 2] + shadow_stack[stack_level - 1];
                        stack_level--;
                    end
                bsm_pkg::MODE_NOP:
                begin
                    r.kind = bsm_pkg::KIND_NOP;
                    results_due.push_back(r);
                end
                default:
                    ; // unused code: no result, no state change
            endcase
        end
    endtask

    task automatic check_result(input bsm_pkg::rsp_t got);
        bsm_pkg::rsp_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind=%0d value=%0d code=%0d last=%0d",
                got.kind, got.out_value, got.error_code, got.last));
            return;
        end
        want = results_due.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.out_value !== want.out_value)
            report_mismatch($sformatf("out_value %0d, want %0d",
                got.out_value, want.out_value));
        if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, want %0d",
                got.error_code, want.error_code));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
    endtask

    // command driver: predicts on every accepted transaction, then idles a random
    // number of cycles before presenting the next one; a stalled payload is held
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                execute_instruction(cmd);
                items_sent++;
                send_gap = pick_wait(send_quiet);
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (program_queue.size() > 0)
                begin
                    cmd <= program_queue.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // result monitor: checks each accepted transaction, then holds stall high
    // for a random number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                check_result(rsp);
                recv_hold = pick_wait(recv_quiet);
            end
            else if (recv_hold > 0)
                recv_hold--;
            rsp_stall <= (recv_hold > 0);
        end
    end

    initial
    begin
        int start_count;
        int pick;
        int floor_level;
        int m;
        logic [2:0] op;
        logic [2:0] fault;

        // directed opening: empty print all, nop, unused code, wrapping adds,
        // swap, multi-element print all and the field extremes
        queue_item(bsm_pkg::MODE_PRINT_ALL, 32'sh0);
        queue_item(bsm_pkg::MODE_NOP, 32'sh7fff_ffff);
        queue_item(MODE_UNUSED, -32'sd1);
        queue_item(bsm_pkg::MODE_PUSH, 32'sh7fff_ffff);
        queue_item(bsm_pkg::MODE_PUSH, 32'sh7fff_ffff);
        queue_item(bsm_pkg::MODE_PRINT_TOP, 32'sh0);
        queue_item(bsm_pkg::MODE_ADD, 32'sh0);
        queue_item(bsm_pkg::MODE_PRINT_TOP, 32'sh0);
        queue_item(bsm_pkg::MODE_PUSH, 32'sh8000_0000);
        queue_item(bsm_pkg::MODE_PUSH, -32'sd1);
        queue_item(bsm_pkg::MODE_SWAP, 32'sh0);
        queue_item(bsm_pkg::MODE_PRINT_ALL, 32'sh0);
        queue_item(bsm_pkg::MODE_ADD, 32'sh0);
        queue_item(bsm_pkg::MODE_PRINT_TOP, 32'sh0);
        queue_item(bsm_pkg::MODE_PUSH, 32'sh0);
        queue_item(bsm_pkg::MODE_PUSH, 32'sh5555_5555);
        queue_item(bsm_pkg::MODE_PUSH, 32'shaaaa_aaaa);
        queue_item(bsm_pkg::MODE_PRINT_ALL, 32'sh0);
        queue_item(bsm_pkg::MODE_POP, 32'sh0);
        queue_item(bsm_pkg::MODE_SWAP, 32'sh0);
        queue_item(bsm_pkg::MODE_POP, 32'sh0);
        queue_item(bsm_pkg::MODE_NOP, 32'sh8000_0000);

        // random legal instruction mix; now and then fill the stack to the top,
        // dump it and bring it back down
        start_count = queued_items;
        while (queued_items - start_count < ITEM_COUNT)
        begin
            if ($urandom_range(0, 99) == 0)
            begin
                while (gen_depth < STACK_DEPTH)
                    queue_item(bsm_pkg::MODE_PUSH, rand_word());
                queue_item(bsm_pkg::MODE_PRINT_ALL, rand_word());
                repeat ($urandom_range(10, 60))
                    queue_item(($urandom_range(0, 1) && gen_depth >= 2) ?
                        bsm_pkg::MODE_ADD : bsm_pkg::MODE_POP, rand_word());
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    op = bsm_pkg::MODE_PUSH;
                else if (pick < 50)
                    op = bsm_pkg::MODE_POP;
                else if (pick < 60)
                    op = bsm_pkg::MODE_SWAP;
                else if (pick < 70)
                    op = bsm_pkg::MODE_ADD;
                else if (pick < 80)
                    op = bsm_pkg::MODE_PRINT_TOP;
                else if (pick < 87)
                    op = bsm_pkg::MODE_PRINT_ALL;
                else if (pick < 95)
                    op = bsm_pkg::MODE_NOP;
                else
                    op = MODE_UNUSED;
                // anything that would fault falls back to a legal push or pop
                if ((op == bsm_pkg::MODE_PUSH && gen_depth >= STACK_DEPTH)
                    || ((op == bsm_pkg::MODE_POP || op == bsm_pkg::MODE_PRINT_TOP)
                        && gen_depth == 0)
                    || ((op == bsm_pkg::MODE_SWAP || op == bsm_pkg::MODE_ADD)
                        && gen_depth < 2))
                    op = (gen_depth < STACK_DEPTH) ? bsm_pkg::MODE_PUSH : bsm_pkg::MODE_POP;
                queue_item(op, rand_word());
            end
        end

        // one fault per run, since only reset clears the halt; the seed picks which
        case ($urandom_range(0, 4))
            0: fault = bsm_pkg::ERR_PRINT_EMPTY;
            1: fault = bsm_pkg::ERR_POP_EMPTY;
            2: fault = bsm_pkg::ERR_SWAP_SHORT;
            3: fault = bsm_pkg::ERR_ADD_SHORT;
            default: fault = bsm_pkg::ERR_OVERFLOW;
        endcase
        case (fault)
            bsm_pkg::ERR_OVERFLOW:
            begin
                while (gen_depth < STACK_DEPTH)
                    queue_item(bsm_pkg::MODE_PUSH, rand_word());
                queue_item(bsm_pkg::MODE_PUSH, rand_word());
            end
            bsm_pkg::ERR_PRINT_EMPTY, bsm_pkg::ERR_POP_EMPTY:
            begin
                while (gen_depth > 0)
                    queue_item(bsm_pkg::MODE_POP, rand_word());
                queue_item((fault == bsm_pkg::ERR_PRINT_EMPTY) ?
                    bsm_pkg::MODE_PRINT_TOP : bsm_pkg::MODE_POP, rand_word());
            end
            default:
            begin
                floor_level = $urandom_range(0, 1);
                while (gen_depth > floor_level)
                    queue_item(bsm_pkg::MODE_POP, rand_word());
                queue_item((fault == bsm_pkg::ERR_SWAP_SHORT) ?
                    bsm_pkg::MODE_SWAP : bsm_pkg::MODE_ADD, rand_word());
            end
        endcase

        // halted: every code, the unused one too, answers with a halted error
        for (m = 0; m < 8; m++)
            queue_item(3'(m), rand_word());
        repeat (8)
            queue_item(3'($urandom_range(0, 7)), rand_word());
        items_total = program_queue.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (items_sent == items_total && results_due.size() == 0);
        // let anything stray come out before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
